>>> sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every module of the block but deq_ram.
package deq_pkg;

    localparam int CMD_W     = 3;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 7;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // perform the request on the store and pointers
    } t_ctrl;

endpackage

>>> sv/double_ended_queue.sv
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+---------------------------
// request  | i_in_valid   | o_in_ready   | i_cmd, i_value, i_index
// result   | o_out_valid  | i_out_ready  | o_data, o_status, o_count
//
// A request is taken in idle, executed on the next cycle (at most one store
// access, pointer and count update), and its result is valid the cycle after that.
// The single store port has registered read data. The result holds until
// taken; no request is taken meanwhile. Synchronous active-low reset empties
// the queue at once.
// Depends on deq_pkg, deq_ctrl, deq_datapath, deq_ram.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_index,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_data,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_count
);

    t_ctrl ctrl;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (ctrl)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .i_index  (i_index),
        .o_data   (o_data),
        .o_status (o_status),
        .o_count  (o_count)
    );

endmodule

>>> sv/deq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/deq_ctrl.sv
// Sequencer for the double-ended queue: request intake, execute, result hold.
// Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_ctrl.load = (r_state == S_IDLE) && i_in_valid;
    assign o_ctrl.exec = (r_state == S_EXEC);

endmodule

>>> sv/deq_datapath.sv
// Datapath for the double-ended queue: request registers, ring pointers,
// slot arithmetic and the word store. Depends on deq_pkg and deq_ram.
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_index,
    output logic signed [DATA_W-1:0] o_data,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int CW = (HW > IDX_W) ? HW : IDX_W;
    localparam int XW = (HW > CNT_W) ? HW : CNT_W;

    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [HW-1:0] FULL_N  = HW'(DEPTH);

    // request registers (payload)
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]         r_index;

    // queue state
    logic [AW-1:0]   r_front, n_front;
    logic [HW-1:0]   r_held, n_held;
    t_status         r_status, n_status;
    logic            r_rd_ok, n_rd_ok;

    logic [CW-1:0]   idx_ext, held_ext;
    logic [AW-1:0]   pos;
    logic [AW:0]     sum;
    logic [AW-1:0]   slot;
    logic [AW-1:0]   front_dec, front_inc;
    logic            full, empty, idx_ok;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_addr;
    logic [DATA_W-1:0] ram_q;
    logic [XW-1:0]   held_x;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
            r_index <= i_index;
        end
    end

    assign idx_ext  = CW'(r_index);
    assign held_ext = CW'(r_held);
    assign full     = (r_held == FULL_N);
    assign empty    = (r_held == '0);
    assign idx_ok   = (idx_ext < held_ext);

    // position from the front; only used where it is below DEPTH
    assign pos = (r_cmd == CMD_PUSH_BACK) ? held_ext[AW-1:0] : idx_ext[AW-1:0];
    assign sum = {1'b0, r_front} + {1'b0, pos};
    assign slot = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : sum[AW-1:0];

    assign front_dec = (r_front == '0) ? LAST : r_front - 1'b1;
    assign front_inc = (r_front == LAST) ? '0 : r_front + 1'b1;

    always_comb begin
        n_front  = r_front;
        n_held   = r_held;
        n_status = ST_OK;
        n_rd_ok  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = slot;
        case (r_cmd)
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_held = r_held + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                ram_addr = front_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_front = front_dec;
                    n_held  = r_held + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_held = r_held - 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_held  = r_held - 1'b1;
                end
            end
            CMD_READ: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    ram_re  = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    ram_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_held   <= '0;
            r_status <= ST_OK;
            r_rd_ok  <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_front  <= n_front;
            r_held   <= n_held;
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_ctrl.exec),
        .i_re    (ram_re && i_ctrl.exec),
        .i_addr  (ram_addr),
        .i_wdata ($unsigned(r_value)),
        .o_rdata (ram_q)
    );

    assign held_x   = XW'(r_held);
    assign o_data   = r_rd_ok ? $signed(ram_q) : '0;
    assign o_status = r_status;
    assign o_count  = held_x[CNT_W-1:0];

endmodule
